/* design/keypad_code_lock_core_defines.svh */
// Assertion macros for the keypad code lock.
// Used by the checker; needs clk and rst in the scope where the macros expand.
`ifndef KEYPAD_CODE_LOCK_CORE_DEFINES_SVH
`define KEYPAD_CODE_LOCK_CORE_DEFINES_SVH

// Same-cycle implication, skipped while reset is high.
`define KCL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, skipped while reset is high.
`define KCL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define KCL_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* design/kcl_pkg.sv */
// Package for the keypad code lock: item types, event and status codes,
// code length and the factory code. No dependencies.
package kcl_pkg;

  localparam int CODE_LENGTH = 6;
  localparam int POS_W       = $clog2(CODE_LENGTH + 1);

  // Event kinds
  localparam logic [1:0] FUNC_DIGIT  = 2'd0;
  localparam logic [1:0] FUNC_CLEAR  = 2'd1;
  localparam logic [1:0] FUNC_ENTER  = 2'd2;
  localparam logic [1:0] FUNC_CHANGE = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_DIGIT    = 3'd0;
  localparam logic [2:0] ST_CLEARED  = 3'd1;
  localparam logic [2:0] ST_UNLOCKED = 3'd2;
  localparam logic [2:0] ST_WRONG    = 3'd3;
  localparam logic [2:0] ST_CHANGED  = 3'd4;
  localparam logic [2:0] ST_MODE_ON  = 3'd5;
  localparam logic [2:0] ST_MODE_OFF = 3'd6;

  localparam logic [3:0] MAX_DIGIT = 4'd9;

  typedef logic [CODE_LENGTH-1:0][3:0] code_t;

  typedef struct packed {
    logic [1:0] func;
    logic [3:0] digit;
  } kcl_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic       unlock;
  } kcl_out_t;

  localparam int         BASE_LEN = 6;
  localparam logic [3:0] BASE_CODE [BASE_LEN] = '{4'd2, 4'd7, 4'd0, 4'd9, 4'd5, 4'd6};

  // Factory code: base digits first, zero beyond them.
  function automatic code_t kcl_default_code();
    code_t c;
    c = '0;
    for (int k = 0; k < CODE_LENGTH; k++) begin
      if (k < BASE_LEN) begin
        c[k] = BASE_CODE[k];
      end
    end
    return c;
  endfunction

  localparam code_t DEFAULT_CODE = kcl_default_code();

endpackage

/* design/keypad_code_lock_core.sv */
// Keypad code lock core: entry buffer, stored code and change mode.
// Depends on kcl_pkg.
//
//  channel | signals                         | moves
//  --------+---------------------------------+-------------------------------
//  key     | key_valid, key_ready, key_item  | one keypad or button event
//  res     | res_valid, res_ready, res_item  | one status result per event
//
// An accepted item is captured in the input register; the decode/compare
// logic then loads its result into the result register once that register
// is free or draining. One item per cycle is sustained while res_ready is
// high.
// Reset (rst, synchronous) restores the factory code, clears the entry,
// the position and change mode, and empties both registers.
// A stalled result holds the processing stage; the input register still
// takes one more item, then key_ready drops until the result moves.
module keypad_code_lock_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             key_valid,
  output logic             key_ready,
  input  kcl_pkg::kcl_in_t key_item,
  output logic             res_valid,
  input  logic             res_ready,
  output kcl_pkg::kcl_out_t res_item
);
  import kcl_pkg::*;

  // Input register
  logic    in_vld;
  kcl_in_t in_q;

  // Lock state
  code_t            entry_digits, entry_digits_next;
  code_t            code_digits, code_digits_next;
  logic [POS_W-1:0] entry_position, entry_position_next;
  logic             change_mode, change_mode_next;

  kcl_out_t res_next;
  logic     fire;
  logic     code_match;

  // Process the held item whenever the result register is free or draining.
  assign fire      = in_vld && (!res_valid || res_ready);
  assign key_ready = !in_vld || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (key_ready) begin
      in_vld <= key_valid;
    end
    if (key_valid && key_ready) begin
      in_q <= key_item;
    end
  end

  // Full-width compare of entry against the stored code.
  assign code_match = (entry_digits == code_digits);

  always_comb begin
    entry_digits_next   = entry_digits;
    code_digits_next    = code_digits;
    entry_position_next = entry_position;
    change_mode_next    = change_mode;
    res_next.status     = ST_DIGIT;
    res_next.unlock     = 1'b0;

    unique case (in_q.func)
      FUNC_DIGIT: begin
        // Digits above nine and digits past a full buffer are dropped.
        if (in_q.digit <= MAX_DIGIT && entry_position < POS_W'(CODE_LENGTH)) begin
          for (int k = 0; k < CODE_LENGTH; k++) begin
            if (entry_position == POS_W'(k)) begin
              entry_digits_next[k] = in_q.digit;
            end
          end
          entry_position_next = entry_position + POS_W'(1);
        end
        res_next.status = ST_DIGIT;
      end
      FUNC_CLEAR: begin
        entry_digits_next   = '0;
        entry_position_next = '0;
        res_next.status     = ST_CLEARED;
      end
      FUNC_ENTER: begin
        entry_position_next = '0;
        if (change_mode) begin
          // New code taken as entered, no compare.
          code_digits_next = entry_digits;
          change_mode_next = 1'b0;
          res_next.status  = ST_CHANGED;
        end else if (code_match) begin
          res_next.status = ST_UNLOCKED;
          res_next.unlock = 1'b1;
        end else begin
          res_next.status = ST_WRONG;
        end
      end
      FUNC_CHANGE: begin
        entry_position_next = '0;
        if (code_match) begin
          change_mode_next = !change_mode;
          res_next.status  = change_mode ? ST_MODE_OFF : ST_MODE_ON;
        end else begin
          res_next.status = ST_WRONG;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_digits   <= '0;
      code_digits    <= DEFAULT_CODE;
      entry_position <= '0;
      change_mode    <= 1'b0;
      res_valid      <= 1'b0;
    end else begin
      if (fire) begin
        entry_digits   <= entry_digits_next;
        code_digits    <= code_digits_next;
        entry_position <= entry_position_next;
        change_mode    <= change_mode_next;
        res_valid      <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
    if (fire) begin
      res_item <= res_next;
    end
  end

endmodule

/* design/kcl_checker.sv */
// Port-level checker for the keypad code lock, bound to keypad_code_lock_core.
// Depends on kcl_pkg and keypad_code_lock_core_defines.svh.
`include "keypad_code_lock_core_defines.svh"

module kcl_checker (
  input logic              clk,
  input logic              rst,
  input logic              key_valid,
  input logic              key_ready,
  input kcl_pkg::kcl_in_t  key_item,
  input logic              res_valid,
  input logic              res_ready,
  input kcl_pkg::kcl_out_t res_item
);
  import kcl_pkg::*;

  logic key_take;
  logic key_first;
  logic unlock_ok;
  logic status_ok;
  logic res_stall;
  logic digit_res;
  assign key_take  = key_valid && key_ready && (key_item.func == FUNC_DIGIT);
  assign key_first = key_take && !res_valid;
  assign unlock_ok = res_item.unlock == (res_item.status == ST_UNLOCKED);
  assign status_ok = res_item.status <= ST_MODE_OFF;
  assign res_stall = res_valid && !res_ready;
  assign digit_res = res_valid && res_item.status == ST_DIGIT && !res_item.unlock;

  // unlock is set exactly on an unlocked result
  `KCL_ASSERT_NOW(a_unlock_status, res_valid, unlock_ok, "unlock flag disagrees with status")

  // no status beyond the defined codes
  `KCL_ASSERT_NOW(a_status_range, res_valid, status_ok, "undefined status code")

  // a stalled result holds
  `KCL_ASSERT_NEXT(a_res_hold, res_stall, res_valid && $stable(res_item), "stalled result changed")

  // reset leaves no result pending and the input side open
  `KCL_ASSERT_ALWAYS(a_reset_empty, rst, !res_valid && key_ready, "result or stall survived reset")

  // a digit key taken with the output empty, followed by a ready cycle, has
  // its digit result showing in the cycle after that ready cycle (an older item
  // ahead of it drains through that ready cycle)
  `KCL_ASSERT_NEXT(a_digit_result, key_first ##1 res_ready, digit_res, "digit key gave wrong result")

endmodule

bind keypad_code_lock_core kcl_checker u_kcl_checker (.*);
